>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is low
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/gqls_pkg.sv
// package with constants, types and helpers of the gridworld q-learning step
`timescale 1ns / 1ps
package gqls_pkg;
   localparam int ROWS_MAX_DEF = 32;
   localparam int COLUMNS_MAX_DEF = 32;
   localparam int Q_WIDTH_DEF = 16;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [1:0] KIND_GOAL = 2'd1;
   localparam logic [1:0] KIND_OPEN = 2'd2;
   localparam logic [1:0] KIND_WALL = 2'd3;

   localparam logic [1:0] MOVE_UP = 2'd0;
   localparam logic [1:0] MOVE_DOWN = 2'd1;
   localparam logic [1:0] MOVE_LEFT = 2'd2;
   localparam logic [1:0] MOVE_RIGHT = 2'd3;

   localparam logic [2:0] REG_LR = 3'd0;
   localparam logic [2:0] REG_DISC = 3'd1;
   localparam logic [2:0] REG_STEP_REW = 3'd2;
   localparam logic [2:0] REG_BLK_REW = 3'd3;
   localparam logic [2:0] REG_LIMIT = 3'd4;
   localparam logic [2:0] REG_ROWS = 3'd5;
   localparam logic [2:0] REG_COLS = 3'd6;

   typedef struct packed {
      logic [1:0] action;
      logic [9:0] cell_index;
      logic [1:0] cell_kind;
      logic       explore;
      logic [1:0] random_move;
   } req_type;

   typedef struct packed {
      logic [4:0]         from_row;
      logic [4:0]         from_column;
      logic [1:0]         move_taken;
      logic               was_blocked;
      logic signed [15:0] q_updated;
      logic               episode_end;
      logic               reached_goal;
   } rsp_type;
endpackage

>>> hdl/gqls_stream_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface gqls_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/gridworld_q_learning_step.sv
// gridworld q-learning step: map and q table memories with a sequenced update
//
//  channel | dir | content
//  req     | in  | action, cell_index, cell_kind, explore, random_move
//  rsp     | out | from_row, from_column, move_taken, was_blocked, q_updated, ...
//  csr     | in  | apb register writes and reads
//
// a step item goes from its transfer to a valid result through eight q table reads over
// one read port (a wall at the target sends it back for a second map read), the shared multiplier
// used twice, then the write back; the next item is taken the cycle after the result leaves
// load and restart items are done in the idle state as they are taken
// after reset a clearing pass sweeps both memories, all 4096 q entries; no item is taken
// the result waits in an output register; no new item is taken until it leaves
`timescale 1ns / 1ps
module gridworld_q_learning_step
   import gqls_pkg::*;
#(
   parameter int ROWS_MAX = ROWS_MAX_DEF,
   parameter int COLUMNS_MAX = COLUMNS_MAX_DEF,
   parameter int Q_WIDTH = Q_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gqls_stream_if.sink   req,
   gqls_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
`include "assert_macros.svh"

   localparam int RB = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int CB = (COLUMNS_MAX > 1) ? $clog2(COLUMNS_MAX) : 1;
   localparam int AB = RB + CB;
   localparam int DEPTH = 1 << AB;
   localparam int QAB = AB + 2;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDQ   = 4'd2;
   localparam logic [3:0] S_PICK  = 4'd3;
   localparam logic [3:0] S_MAP   = 4'd4;
   localparam logic [3:0] S_MOVE  = 4'd5;
   localparam logic [3:0] S_RDM   = 4'd6;
   localparam logic [3:0] S_MUL1  = 4'd7;
   localparam logic [3:0] S_SUM   = 4'd8;
   localparam logic [3:0] S_MUL2  = 4'd9;
   localparam logic [3:0] S_WB    = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   // config registers
   logic [15:0] lr_ff, disc_ff, srew_ff, brew_ff;
   logic [7:0]  limit_ff;
   logic [5:0]  rows_ff, cols_ff;

   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 16'd6554;
         disc_ff <= 16'd62259;
         srew_ff <= 16'hFF9A;
         brew_ff <= 16'hFC00;
         limit_ff <= 8'd150;
         rows_ff <= 6'd20;
         cols_ff <= 6'd30;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_LR:       lr_ff <= csr_pwdata[15:0];
            REG_DISC:     disc_ff <= csr_pwdata[15:0];
            REG_STEP_REW: srew_ff <= csr_pwdata[15:0];
            REG_BLK_REW:  brew_ff <= csr_pwdata[15:0];
            REG_LIMIT:    limit_ff <= csr_pwdata[7:0];
            REG_ROWS:     rows_ff <= csr_pwdata[5:0];
            REG_COLS:     cols_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_LR:       csr_prdata = {16'd0, lr_ff};
         REG_DISC:     csr_prdata = {16'd0, disc_ff};
         REG_STEP_REW: csr_prdata = {16'd0, srew_ff};
         REG_BLK_REW:  csr_prdata = {16'd0, brew_ff};
         REG_LIMIT:    csr_prdata = {24'd0, limit_ff};
         REG_ROWS:     csr_prdata = {26'd0, rows_ff};
         REG_COLS:     csr_prdata = {26'd0, cols_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // used area, clamped to 1..max
   logic [8:0] rows_used, cols_used;
   always_comb begin
      if (rows_ff == 6'd0) rows_used = 9'd1;
      else if (32'(rows_ff) > ROWS_MAX) rows_used = 9'(ROWS_MAX);
      else rows_used = {3'd0, rows_ff};
      if (cols_ff == 6'd0) cols_used = 9'd1;
      else if (32'(cols_ff) > COLUMNS_MAX) cols_used = 9'(COLUMNS_MAX);
      else cols_used = {3'd0, cols_ff};
   end

   // memories
   logic [1:0]         map_mem [DEPTH];
   logic [Q_WIDTH-1:0] q_mem [DEPTH*4];
   logic [1:0]         map_rd_ff;
   logic [Q_WIDTH-1:0] q_rd_ff;
   logic               map_we, q_we;
   logic [AB-1:0]      map_waddr, map_raddr;
   logic [1:0]         map_wdata;
   logic [QAB-1:0]     q_waddr, q_raddr;
   logic [Q_WIDTH-1:0] q_wdata;

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[q_raddr];
   end

   // control and datapath
   logic [3:0]  state_ff, state_in;
   logic [QAB-1:0] clr_ff, clr_in;
   logic [RB-1:0] arow_ff, arow_in, nrow_ff, nrow_in;
   logic [CB-1:0] acol_ff, acol_in, ncol_ff, ncol_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [2:0]  rd_ff, rd_in;
   req_type     item_ff, item_in;
   logic [1:0]  mv_ff, mv_in;
   logic        blk_ff, blk_in;
   logic signed [Q_WIDTH-1:0] q_ff, q_in, m_ff, m_in, best_ff, best_in;
   logic signed [Q_WIDTH-1:0] qv [4];
   logic signed [Q_WIDTH-1:0] qv_in [4];
   logic signed [48:0] acc_ff, acc_in;
   logic signed [Q_WIDTH+18:0] t_ff, t_in;
   rsp_type     out_ff, out_in;
   logic        out_vld_ff, out_vld_in;
   logic        edge_ok;
   logic [RB-1:0] trow;
   logic [CB-1:0] tcol;
   logic signed [Q_WIDTH+18:0] rw_ext;

   // shared multiplier, Q_WIDTH+20 by 18 bits signed (36 x 18 at the default q width)
   logic signed [Q_WIDTH+19:0] mul_a;
   logic signed [17:0]         mul_b;
   logic signed [Q_WIDTH+37:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [48:0]        nq_wide;
   logic signed [Q_WIDTH-1:0] nq;
   logic signed [15:0]        nq16;
   logic [7:0] cnt_next;
   logic [7:0] lim;
   localparam logic signed [Q_WIDTH+1:0] QMAX = (Q_WIDTH+2)'((64'sd1 <<< (Q_WIDTH-1)) - 1);
   localparam logic signed [Q_WIDTH+1:0] QMIN = -QMAX - 1;

   assign req.ready = (state_ff == S_IDLE) && !out_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      arow_in = arow_ff; acol_in = acol_ff;
      nrow_in = nrow_ff; ncol_in = ncol_ff;
      cnt_in = cnt_ff; rd_in = rd_ff;
      item_in = item_ff; mv_in = mv_ff; blk_in = blk_ff;
      q_in = q_ff; m_in = m_ff; best_in = best_ff;
      for (int i = 0; i < 4; i++) qv_in[i] = qv[i];
      acc_in = acc_ff; t_in = t_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp.ready;
      map_we = 1'b0; q_we = 1'b0;
      map_waddr = clr_ff[QAB-1:2]; map_wdata = KIND_OPEN;
      q_waddr = clr_ff; q_wdata = '0;
      map_raddr = {nrow_ff, ncol_ff};
      q_raddr = {arow_ff, acol_ff, rd_ff[1:0]};
      mul_a = '0; mul_b = '0;
      edge_ok = 1'b0; trow = arow_ff; tcol = acol_ff;
      nq_wide = '0; nq = '0; nq16 = '0;
      cnt_next = cnt_ff + 8'd1;
      lim = (limit_ff == 8'd0) ? 8'd1 : limit_ff;
      rw_ext = '0;
      unique case (state_ff)
         S_CLEAR: begin
            // one q entry per cycle, the map entry on the first of its four
            map_we = clr_ff[1:0] == 2'b00;
            q_we = 1'b1;
            map_waddr = clr_ff[QAB-1:2];
            q_waddr = clr_ff;
            clr_in = clr_ff + QAB'(1);
            if (clr_ff == QAB'(DEPTH*4 - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.payload;
               unique case (req.payload.action)
                  ACT_LOAD: begin
                     if (32'(req.payload.cell_index[9:5]) < ROWS_MAX &&
                         32'(req.payload.cell_index[4:0]) < COLUMNS_MAX) begin
                        map_we = 1'b1;
                        map_waddr = {RB'(req.payload.cell_index[9:5]),
                                     CB'(req.payload.cell_index[4:0])};
                        map_wdata = req.payload.cell_kind;
                     end
                  end
                  ACT_RESTART: begin
                     arow_in = '0; acol_in = '0; cnt_in = '0;
                  end
                  ACT_STEP: begin
                     rd_in = 3'd0;
                     state_in = S_RDQ;
                  end
                  default: ;
               endcase
            end
         end
         S_RDQ: begin
            // issue reads 0..3, capture one behind
            q_raddr = {arow_ff, acol_ff, rd_ff[1:0]};
            if (rd_ff != 3'd0) qv_in[rd_ff[1:0] - 2'd1] = q_rd_ff;
            rd_in = rd_ff + 3'd1;
            if (rd_ff == 3'd4) begin
               qv_in[3] = q_rd_ff;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (item_ff.explore) mv_in = item_ff.random_move;
            else begin
               mv_in = MOVE_UP;
               best_in = qv[0];
               for (int a = 1; a < 4; a++)
                  if (qv[a] > best_in) begin best_in = qv[a]; mv_in = 2'(a); end
            end
            state_in = S_MAP;
         end
         S_MAP: begin
            q_in = qv[mv_ff];
            unique case (mv_ff)
               MOVE_UP: begin
                  edge_ok = arow_ff != '0; trow = arow_ff - 1'b1;
               end
               MOVE_DOWN: begin
                  edge_ok = 9'(arow_ff) + 9'd1 < rows_used; trow = arow_ff + 1'b1;
               end
               MOVE_LEFT: begin
                  edge_ok = acol_ff != '0; tcol = acol_ff - 1'b1;
               end
               default: begin
                  edge_ok = 9'(acol_ff) + 9'd1 < cols_used; tcol = acol_ff + 1'b1;
               end
            endcase
            blk_in = !edge_ok;
            nrow_in = edge_ok ? trow : arow_ff;
            ncol_in = edge_ok ? tcol : acol_ff;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            // map read of target in flight
            map_raddr = {nrow_ff, ncol_ff};
            state_in = S_RDM;
            rd_in = 3'd0;
         end
         S_RDM: begin
            if (rd_ff == 3'd0 && !blk_ff && map_rd_ff == KIND_WALL) begin
               blk_in = 1'b1;
               nrow_in = arow_ff; ncol_in = acol_ff;
               map_raddr = {arow_ff, acol_ff};
               state_in = S_MOVE;
            end else begin
               q_raddr = {nrow_ff, ncol_ff, rd_ff[1:0]};
               if (rd_ff == 3'd2) m_in = q_rd_ff;
               else if (rd_ff > 3'd2 && $signed(q_rd_ff) > m_ff) m_in = q_rd_ff;
               if (rd_ff == 3'd0) out_in.reached_goal = map_rd_ff == KIND_GOAL;
               rd_in = rd_ff + 3'd1;
               if (rd_ff == 3'd5) state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            // discount * m plus reward and old value terms
            mul_a = (Q_WIDTH+20)'(m_ff);
            mul_b = 18'(signed'({1'b0, disc_ff}));
            rw_ext = (Q_WIDTH+19)'(signed'(blk_ff ? brew_ff : srew_ff));
            acc_in = 49'(mul_p) + (49'(rw_ext) <<< 16) - (49'(q_ff) <<< 16) + 49'sd32768;
            state_in = S_SUM;
         end
         S_SUM: begin
            t_in = (Q_WIDTH+19)'(acc_ff >>> 16);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_a = (Q_WIDTH+20)'(t_ff);
            mul_b = 18'(signed'({1'b0, lr_ff}));
            acc_in = 49'(mul_p) + 49'sd32768;
            state_in = S_WB;
         end
         S_WB: begin
            nq_wide = 49'(q_ff) + (acc_ff >>> 16);
            if (nq_wide > 49'(QMAX)) nq = Q_WIDTH'(QMAX);
            else if (nq_wide < 49'(QMIN)) nq = Q_WIDTH'(QMIN);
            else nq = Q_WIDTH'(nq_wide);
            if (Q_WIDTH > 16 && nq > 32767) nq16 = 16'sd32767;
            else if (Q_WIDTH > 16 && nq < -32768) nq16 = -16'sd32768;
            else nq16 = 16'(nq);
            q_we = 1'b1;
            q_waddr = {arow_ff, acol_ff, mv_ff};
            q_wdata = nq;
            out_in.from_row = 5'(arow_ff);
            out_in.from_column = 5'(acol_ff);
            out_in.move_taken = mv_ff;
            out_in.was_blocked = blk_ff;
            out_in.q_updated = nq16;
            out_in.episode_end = out_ff.reached_goal || cnt_next == 8'd0 || cnt_next >= lim;
            out_vld_in = 1'b1;
            if (out_in.episode_end) begin
               arow_in = '0; acol_in = '0; cnt_in = '0;
            end else begin
               arow_in = nrow_ff; acol_in = ncol_ff; cnt_in = cnt_next;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         arow_ff <= '0; acol_ff <= '0; cnt_ff <= '0;
         out_vld_ff <= 1'b0;
         rd_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         arow_ff <= arow_in; acol_ff <= acol_in; cnt_ff <= cnt_in;
         out_vld_ff <= out_vld_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; mv_ff <= mv_in; blk_ff <= blk_in;
      nrow_ff <= nrow_in; ncol_ff <= ncol_in;
      q_ff <= q_in; m_ff <= m_in; best_ff <= best_in;
      for (int i = 0; i < 4; i++) qv[i] <= qv_in[i];
      acc_ff <= acc_in; t_ff <= t_in;
      out_ff <= out_in;
   end

   `ASSERT_CLK(a_no_take_busy, clock, reset, !(req.ready && state_ff != S_IDLE),
      "input taken outside idle")
   `ASSERT_NEXT(a_wb_result, clock, reset, state_ff == S_WB, rsp.valid,
      "write back without result")
   `ASSERT_CLK(a_no_result_clear, clock, reset, !(state_ff == S_CLEAR && rsp.valid),
      "result during clearing pass")
endmodule

>>> verif/gridworld_q_learning_step_tb.sv
// self-checking testbench of the gridworld q-learning step block
`timescale 1ns / 1ps
module gridworld_q_learning_step_tb;
   import gqls_pkg::*;

   localparam int NUM_RANDOM = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gqls_stream_if #(.payload_type(req_type)) req ();
   gqls_stream_if #(.payload_type(rsp_type)) rsp ();

   gridworld_q_learning_step DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [15:0] lr_q, disc_q, step_rew_q, blk_rew_q;
   logic [7:0] limit_q;
   logic [5:0] rows_q, cols_q;
   logic signed [15:0] q_mem [0:1023][0:3];
   logic [1:0] map_mem [0:1023];
   logic [4:0] pos_row, pos_col;
   logic [7:0] step_cnt;

   req_type pending_items[$];
   rsp_type expected_steps[$];
   int errors = 0;
   int sent = 0;
   bit quiet = 1'b0;
   bit drain_hold = 1'b0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint floor16(input longint v);
      return v >>> 16;
   endfunction

   function automatic void predict(input req_type it);
      int r0, c0, r1, c1, rows, cols, a, lim;
      logic [1:0] mv;
      bit blocked, goal, done;
      longint q, m, rew, t, d, nq;
      rsp_type rs;
      if (it.action == ACT_LOAD) begin
         map_mem[it.cell_index] = it.cell_kind;
         return;
      end
      if (it.action == ACT_RESTART) begin
         pos_row = 0; pos_col = 0; step_cnt = 0;
         return;
      end
      if (it.action != ACT_STEP) return;
      r0 = pos_row; c0 = pos_col;
      rows = (rows_q == 0) ? 1 : (rows_q > 32 ? 32 : rows_q);
      cols = (cols_q == 0) ? 1 : (cols_q > 32 ? 32 : cols_q);
      if (it.explore) mv = it.random_move;
      else begin
         mv = MOVE_UP;
         for (a = 1; a < 4; a++)
            if (q_mem[r0*32+c0][a] > q_mem[r0*32+c0][mv]) mv = a[1:0];
      end
      r1 = r0; c1 = c0; blocked = 1'b1;
      case (mv)
         MOVE_UP: if (r0 > 0 && map_mem[(r0-1)*32+c0] != KIND_WALL) begin
            r1 = r0 - 1; blocked = 1'b0;
         end
         MOVE_DOWN: if (r0 + 1 < rows && map_mem[(r0+1)*32+c0] != KIND_WALL) begin
            r1 = r0 + 1; blocked = 1'b0;
         end
         MOVE_LEFT: if (c0 > 0 && map_mem[r0*32+c0-1] != KIND_WALL) begin
            c1 = c0 - 1; blocked = 1'b0;
         end
         default: if (c0 + 1 < cols && map_mem[r0*32+c0+1] != KIND_WALL) begin
            c1 = c0 + 1; blocked = 1'b0;
         end
      endcase
      rew = blocked ? longint'($signed(blk_rew_q)) : longint'($signed(step_rew_q));
      q = q_mem[r0*32+c0][mv];
      m = q_mem[r1*32+c1][0];
      for (a = 1; a < 4; a++)
         if (q_mem[r1*32+c1][a] > m) m = q_mem[r1*32+c1][a];
      t = floor16(rew * 65536 + longint'(disc_q) * m - q * 65536 + 32768);
      d = floor16(longint'(lr_q) * t + 32768);
      nq = q + d;
      if (nq > 32767) nq = 32767;
      if (nq < -32768) nq = -32768;
      q_mem[r0*32+c0][mv] = nq[15:0];
      pos_row = r1; pos_col = c1;
      step_cnt = step_cnt + 8'd1;
      goal = map_mem[r1*32+c1] == KIND_GOAL;
      lim = (limit_q == 0) ? 1 : limit_q;
      done = goal || step_cnt == 0 || step_cnt >= lim;
      rs.from_row = r0; rs.from_column = c0; rs.move_taken = mv;
      rs.was_blocked = blocked; rs.q_updated = nq[15:0];
      rs.episode_end = done; rs.reached_goal = goal;
      expected_steps.push_back(rs);
      if (done) begin
         pos_row = 0; pos_col = 0; step_cnt = 0;
      end
   endfunction

   // driver
   int src_idle = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            predict(req.payload);
            sent++;
         end
         if (src_idle > 0) begin
            src_idle--;
            req.valid <= 1'b0;
         end else if (pending_items.size() > 0 && !drain_hold) begin
            req.payload <= pending_items.pop_front();
            req.valid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) src_idle = $urandom_range(1, 8);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   int dst_idle = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_steps.size() == 0) report("unexpected transfer", 0, 0);
            else begin
               e = expected_steps.pop_front();
               if (rsp.payload.from_row !== e.from_row)
                  report("from_row", rsp.payload.from_row, e.from_row);
               if (rsp.payload.from_column !== e.from_column)
                  report("from_column", rsp.payload.from_column, e.from_column);
               if (rsp.payload.move_taken !== e.move_taken)
                  report("move_taken", rsp.payload.move_taken, e.move_taken);
               if (rsp.payload.was_blocked !== e.was_blocked)
                  report("was_blocked", rsp.payload.was_blocked, e.was_blocked);
               if (rsp.payload.q_updated !== e.q_updated)
                  report("q_updated", rsp.payload.q_updated, e.q_updated);
               if (rsp.payload.episode_end !== e.episode_end)
                  report("episode_end", rsp.payload.episode_end, e.episode_end);
               if (rsp.payload.reached_goal !== e.reached_goal)
                  report("reached_goal", rsp.payload.reached_goal, e.reached_goal);
            end
         end
         if (dst_idle > 0) begin
            dst_idle--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) dst_idle = $urandom_range(1, 8);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_LR: lr_q = val[15:0];
         REG_DISC: disc_q = val[15:0];
         REG_STEP_REW: step_rew_q = val[15:0];
         REG_BLK_REW: blk_rew_q = val[15:0];
         REG_LIMIT: limit_q = val[7:0];
         REG_ROWS: rows_q = val[5:0];
         default: cols_q = val[5:0];
      endcase
   endtask

   // lets everything queued pass and the block settle
   task automatic wait_idle();
      while (pending_items.size() > 0 || req.valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic req_type mk(input logic [1:0] act, input logic [9:0] idx,
                                  input logic [1:0] kind, input logic ex,
                                  input logic [1:0] mv);
      req_type it;
      it.action = act; it.cell_index = idx; it.cell_kind = kind;
      it.explore = ex; it.random_move = mv;
      return it;
   endfunction

   function automatic req_type rnd_step();
      req_type it;
      it = req_type'($urandom);
      it.action = ACT_STEP;
      if ($urandom_range(0, 2) != 0) it.explore = 1'b1;
      return it;
   endfunction

   task automatic random_phase(input int n);
      int i;
      req_type it;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               it = req_type'($urandom);
               it.action = ACT_LOAD;
               if ($urandom_range(0, 1)) it.cell_kind = KIND_WALL;
            end
            2: it = mk(ACT_LOAD, $urandom_range(0, 1023), KIND_GOAL, 0, 0);
            3: it = mk(ACT_RESTART, $urandom, $urandom, $urandom, $urandom);
            4: it = mk(2'd3, $urandom, $urandom, $urandom, $urandom);
            default: it = rnd_step();
         endcase
         pending_items.push_back(it);
      end
   endtask

   initial begin
      int k;
      lr_q = 6554; disc_q = 62259; step_rew_q = -16'sd102; blk_rew_q = -16'sd1024;
      limit_q = 150; rows_q = 20; cols_q = 30;
      for (k = 0; k < 1024; k++) begin
         map_mem[k] = KIND_OPEN;
         q_mem[k][0] = 0; q_mem[k][1] = 0; q_mem[k][2] = 0; q_mem[k][3] = 0;
      end
      pos_row = 0; pos_col = 0; step_cnt = 0;
      req.valid = 1'b0; req.payload = '0; rsp.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset
      repeat (1100) @(posedge clock);

      // directed: edges, walls, goal, greedy, unused code
      pending_items.push_back(mk(ACT_STEP, 0, 0, 1, MOVE_UP));
      pending_items.push_back(mk(ACT_STEP, 0, 0, 1, MOVE_LEFT));
      pending_items.push_back(mk(ACT_STEP, 0, 0, 0, MOVE_UP));
      pending_items.push_back(mk(ACT_LOAD, 10'd1, KIND_WALL, 0, 0));
      pending_items.push_back(mk(ACT_STEP, 0, 0, 1, MOVE_RIGHT));
      pending_items.push_back(mk(ACT_LOAD, 10'd32, KIND_GOAL, 0, 0));
      pending_items.push_back(mk(ACT_STEP, 0, 0, 1, MOVE_DOWN));
      pending_items.push_back(mk(ACT_STEP, 0, 0, 1, MOVE_DOWN));
      pending_items.push_back(mk(ACT_LOAD, 10'd1023, KIND_OPEN, 0, 0));
      pending_items.push_back(mk(ACT_LOAD, 10'd0, 2'd0, 1, 3));
      pending_items.push_back(mk(2'd3, 10'h3ff, 2'd3, 1, 3));
      pending_items.push_back(mk(ACT_STEP, 10'h3ff, 2'd3, 0, 3));
      pending_items.push_back(mk(ACT_RESTART, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_LOAD, 10'd1, KIND_OPEN, 0, 0));
      pending_items.push_back(mk(ACT_LOAD, 10'd32, KIND_OPEN, 0, 0));
      wait_idle();

      // extreme settings, small grid, step limit edges
      csr_write(REG_LR, 32'hffff); csr_write(REG_DISC, 32'hffff);
      csr_write(REG_STEP_REW, 32'h8000); csr_write(REG_BLK_REW, 32'h0000);
      csr_write(REG_LIMIT, 32'd0); csr_write(REG_ROWS, 32'd0);
      csr_write(REG_COLS, 32'd63);
      random_phase(60);
      wait_idle();
      csr_write(REG_LR, 32'h0); csr_write(REG_DISC, 32'h0);
      csr_write(REG_STEP_REW, 32'h0); csr_write(REG_BLK_REW, 32'h8000);
      csr_write(REG_LIMIT, 32'd255); csr_write(REG_ROWS, 32'd32);
      csr_write(REG_COLS, 32'd1);
      random_phase(60);
      // pause until every result is in
      drain_hold = 1'b1;
      while (expected_steps.size() > 0 || req.valid) @(posedge clock);
      drain_hold = 1'b0;
      wait_idle();

      // mid settings, agent may sit outside the shrunken area
      csr_write(REG_ROWS, 32'd4); csr_write(REG_COLS, 32'd5);
      csr_write(REG_LIMIT, 32'd12);
      csr_write(REG_LR, 32'd30000); csr_write(REG_DISC, 32'd60000);
      csr_write(REG_STEP_REW, 32'hff9a);
      random_phase(200);
      wait_idle();
      csr_write(REG_ROWS, 32'd8); csr_write(REG_COLS, 32'd8);
      csr_write(REG_LIMIT, 32'd40); csr_write(REG_BLK_REW, 32'hfc00);
      random_phase(200);
      wait_idle();
      csr_write(REG_ROWS, 32'd32); csr_write(REG_COLS, 32'd32);
      csr_write(REG_LIMIT, 32'd200); csr_write(REG_LR, 32'd6554);
      random_phase(200);
      while (pending_items.size() > 40) @(posedge clock);
      quiet = 1'b1;
      random_phase(80);
      while (pending_items.size() > 0 || req.valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
